### src/ipa_pkg.sv
// ipa_pkg: shared constants, opcodes and the command/status structs for the
// IPv4 prefix aggregator. No dependencies.
package ipa_pkg;

  // Default size of one counting unit, as a prefix length.
  localparam int DEF_UNIT_PREFIX = 24;

  // Most blocks emitted for one ended run.
  localparam int MAX_BLOCKS = 48;
  localparam int CNT_W      = $clog2(MAX_BLOCKS);

  // Request opcodes.
  localparam logic OP_ENTRY = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Controller -> datapath commands.
  typedef struct packed {
    logic load_run;    // open a new run from the input request
    logic merge;       // add the input request to the open run
    logic clear_run;   // close the run without opening another
    logic start_emit;  // copy the open run into the emitter
    logic emit_step;   // produce one block into the output register
  } ipa_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    logic run_active;  // a run is open
    logic entry_ok;    // prefix length is within range
    logic joins;       // entry continues the open run and fits
    logic out_free;    // output register can take a block this cycle
    logic emit_done;   // the block being produced is the run's final one
  } ipa_sts_t;

endpackage

### src/ipa_ctrl.sv
// ipa_ctrl: request sequencer for the prefix aggregator.
// Depends on ipa_pkg (opcodes, command and status structs).
module ipa_ctrl import ipa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     opcode,
  input  ipa_sts_t sts,
  output logic     in_stall,
  output ipa_cmd_t cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  assign in_stall = (state == ST_EMIT);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (opcode == OP_FLUSH) begin
            if (sts.run_active) begin
              cmd.start_emit = 1'b1;
              cmd.clear_run  = 1'b1;
              state_next     = ST_EMIT;
            end
          end else if (sts.entry_ok) begin
            if (!sts.run_active) begin
              cmd.load_run = 1'b1;
            end else if (sts.joins) begin
              cmd.merge = 1'b1;
            end else begin
              // break in the run: emit the old one, open the new one now
              cmd.start_emit = 1'b1;
              cmd.load_run   = 1'b1;
              state_next     = ST_EMIT;
            end
          end
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_done) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### src/ipa_dp.sv
// ipa_dp: run registers, block emitter and output register of the aggregator.
// Depends on ipa_pkg (command and status structs, block limit).
module ipa_dp import ipa_pkg::*; #(
  parameter int UNIT_PREFIX = DEF_UNIT_PREFIX
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] net_address,
  input  logic [4:0]  prefix_len,
  input  ipa_cmd_t    cmd,
  input  logic        out_stall,
  output ipa_sts_t    sts,
  output logic        out_valid,
  output logic [31:0] block_address,
  output logic [4:0]  block_prefix,
  output logic        last_block
);

  localparam int UNIT_SHIFT = 32 - UNIT_PREFIX;
  localparam int UW         = UNIT_PREFIX + 1;
  localparam logic [UW:0] FULL_UNITS = (UW+1)'(1) << UNIT_PREFIX;

  // open run
  logic                   run_active;
  logic [31:0]            run_base;
  logic [UW-1:0]          run_units;
  logic [31:0]            next_expected;

  // emitter
  logic [UNIT_PREFIX-1:0] emit_bu;
  logic [UW-1:0]          emit_rem;
  logic [CNT_W-1:0]       emit_cnt;

  // input decode
  logic [UNIT_PREFIX-1:0] in_unit;
  logic [31:0]            in_addr;
  logic [UW-1:0]          in_units;
  logic [32:0]            in_span;
  logic [31:0]            in_next;
  logic [UW:0]            units_sum;

  assign in_unit   = UNIT_PREFIX'(net_address >> UNIT_SHIFT);
  assign in_addr   = 32'(in_unit) << UNIT_SHIFT;
  assign in_units  = UW'(1) << (UNIT_PREFIX - int'(prefix_len));
  assign in_span   = 33'(1) << (32 - int'(prefix_len));
  assign in_next   = 32'(33'(in_addr) + in_span);
  assign units_sum = (UW+1)'(run_units) + (UW+1)'(in_units);

  // block size: largest power of two within the remainder, capped by base alignment
  logic [UW-1:0]          smear;
  logic [UW-1:0]          rem_pow;
  logic [UNIT_PREFIX-1:0] bu_low;
  logic [UW-1:0]          size;
  logic [5:0]             lg;
  logic [UW-1:0]          rem_after;

  always_comb begin
    smear = emit_rem;
    for (int i = 1; i < UW; i = i * 2) begin
      smear = smear | (smear >> i);
    end
    rem_pow = smear ^ (smear >> 1);
    bu_low  = emit_bu & (~emit_bu + 1'b1);
    if (bu_low != '0 && UW'(bu_low) < rem_pow) begin
      size = UW'(bu_low);
    end else begin
      size = rem_pow;
    end
    lg = '0;
    for (int i = 0; i < UW; i++) begin
      if (size[i]) lg = lg | 6'(i);
    end
  end

  assign rem_after = emit_rem - size;

  assign sts.run_active = run_active;
  assign sts.entry_ok   = {1'b0, prefix_len} <= 6'(UNIT_PREFIX);
  assign sts.joins      = (in_addr == next_expected) && (units_sum <= FULL_UNITS);
  assign sts.out_free   = !out_valid || !out_stall;
  assign sts.emit_done  = (rem_after == '0) || (emit_cnt == CNT_W'(MAX_BLOCKS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
    end else if (cmd.load_run) begin
      run_active <= 1'b1;
    end else if (cmd.clear_run) begin
      run_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_emit) begin
      emit_bu  <= UNIT_PREFIX'(run_base >> UNIT_SHIFT);
      emit_rem <= run_units;
      emit_cnt <= '0;
    end else if (cmd.emit_step) begin
      emit_bu  <= emit_bu + UNIT_PREFIX'(size);
      emit_rem <= rem_after;
      emit_cnt <= emit_cnt + 1'b1;
    end
    if (cmd.load_run) begin
      run_base      <= in_addr;
      run_units     <= in_units;
      next_expected <= in_next;
    end else if (cmd.merge) begin
      run_units     <= UW'(units_sum);
      next_expected <= in_next;
    end
    if (cmd.emit_step) begin
      block_address <= 32'(emit_bu) << UNIT_SHIFT;
      block_prefix  <= 5'(6'(UNIT_PREFIX) - lg);
      last_block    <= (rem_after == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### src/ipv4_prefix_aggregator.sv
// ipv4_prefix_aggregator: top level, merges a sorted stream of IPv4 networks
// into covering CIDR blocks. Depends on ipa_pkg, ipa_ctrl and ipa_dp.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in      | input     | in_valid / in_stall   | opcode, net_address, prefix_len
//   out     | output    | out_valid / out_stall | block_address, block_prefix, last_block
//
// An entry that joins or opens a run, a long-prefix entry and an idle flush
// are each taken while the sequencer stays idle. A request that ends a run is
// taken, then the emitter produces its blocks (up to MAX_BLOCKS), one block a
// cycle unless out_stall holds it. in_stall is high while blocks are being emitted.
// Synchronous reset closes any open run and empties the output register.
module ipv4_prefix_aggregator import ipa_pkg::*; #(
  parameter int UNIT_PREFIX = DEF_UNIT_PREFIX
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] net_address,
  input  logic [4:0]  prefix_len,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] block_address,
  output logic [4:0]  block_prefix,
  output logic        last_block
);

  ipa_cmd_t cmd;
  ipa_sts_t sts;

  // Sequencer: decides merge / open / emit per request.
  ipa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .opcode   (opcode),
    .sts      (sts),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  // Run registers, greedy block emitter, output register.
  ipa_dp #(
    .UNIT_PREFIX (UNIT_PREFIX)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .net_address   (net_address),
    .prefix_len    (prefix_len),
    .cmd           (cmd),
    .out_stall     (out_stall),
    .sts           (sts),
    .out_valid     (out_valid),
    .block_address (block_address),
    .block_prefix  (block_prefix),
    .last_block    (last_block)
  );

  // A new block only appears while the emitter is running.
  a_out_from_emit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $rose(out_valid)) |-> $past(in_stall))
    else $error("output block appeared outside emission");

  // Emission always ends with its final block held in the output register.
  a_emit_ends_full: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && $fell(in_stall)) |-> out_valid)
    else $error("emission ended without a block in the output register");

  // Emitted blocks are never smaller than the unit size.
  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ({1'b0, block_prefix} <= 6'(UNIT_PREFIX)))
    else $error("block prefix out of range");

endmodule

### tb/sv/ipa_block_checker.sv
`timescale 1ns / 1ps
// ipa_block_checker: watches both channels of ipv4_prefix_aggregator, predicts the
// covering blocks each request produces and compares them in order. Uses ipa_pkg.
module ipa_block_checker import ipa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        opcode,
  input  logic [31:0] net_address,
  input  logic [4:0]  prefix_len,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] block_address,
  input  logic [4:0]  block_prefix,
  input  logic        last_block,
  output int          fail_count,
  output int          pending,
  output int          req_count,
  output int          blk_count
);

  localparam int UP = DEF_UNIT_PREFIX;
  localparam int SH = 32 - UP;
  localparam logic [UP:0] FULL_SPACE = (UP + 1)'(1) << UP;

  typedef struct packed {
    logic [31:0] addr;
    logic [4:0]  plen;
    logic        last;
  } cover_blk_t;

  cover_blk_t  expected_blocks[$];
  logic [31:0] run_base;
  logic [31:0] run_next;
  logic [UP:0] run_units;
  logic        run_open;
  int          misses = 0;
  int          reqs = 0;
  int          blks = 0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch %s: got %h, want %h", $time, what, got, want);
    misses++;
  endtask

  // Greedy cover of the open run: largest power of two that fits, shrunk to alignment.
  function automatic void cover_run();
    logic [UP-1:0] bu;
    logic [UP:0]   rem;
    logic [UP:0]   size;
    int            lg;
    int            n;
    cover_blk_t    b;
    bu  = run_base[31:SH];
    rem = run_units;
    n   = 0;
    while (rem != 0 && n < MAX_BLOCKS) begin
      size = 1;
      lg   = 0;
      while (lg < UP && (size << 1) <= rem) begin
        size = size << 1;
        lg++;
      end
      while (lg > 0 && ({1'b0, bu} & (size - 1)) != 0) begin
        size = size >> 1;
        lg--;
      end
      rem    = rem - size;
      b.addr = 32'(bu) << SH;
      b.plen = 5'(UP - lg);
      b.last = (rem == 0);
      expected_blocks.push_back(b);
      bu = bu + size[UP-1:0];
      n++;
    end
    run_open = 1'b0;
  endfunction

  function automatic void aggregate_request(input logic op, input logic [31:0] addr,
                                            input logic [4:0] plen);
    logic [31:0] a;
    logic [UP:0] units;
    logic [32:0] span;
    if (op == OP_FLUSH) begin
      if (run_open) cover_run();
    end else if (plen <= UP) begin
      a     = (addr >> SH) << SH;
      units = (UP + 1)'(1) << (UP - plen);
      span  = 33'd1 << (32 - plen);
      if (run_open && (a != run_next ||
                       ({1'b0, run_units} + {1'b0, units}) > {1'b0, FULL_SPACE}))
        cover_run();
      if (!run_open) begin
        run_base  = a;
        run_units = units;
        run_open  = 1'b1;
      end else begin
        run_units = run_units + units;
      end
      run_next = a + span[31:0];
    end
  endfunction

  task automatic check_block();
    cover_blk_t want;
    if (expected_blocks.size() == 0) begin
      report_mismatch("block with none expected", block_address, 32'd0);
    end else begin
      want = expected_blocks.pop_front();
      blks++;
      if (block_address !== want.addr)
        report_mismatch("block_address", block_address, want.addr);
      if (block_prefix !== want.plen)
        report_mismatch("block_prefix", 32'(block_prefix), 32'(want.plen));
      if (last_block !== want.last)
        report_mismatch("last_block", 32'(last_block), 32'(want.last));
    end
  endtask

  // Output side first: a block leaving now can never stem from a request entering now.
  always @(posedge clk) begin
    if (rst) begin
      run_base  = '0;
      run_next  = '0;
      run_units = '0;
      run_open  = 1'b0;
      expected_blocks.delete();
    end else begin
      if (out_valid && !out_stall) check_block();
      if (in_valid && !in_stall) begin
        reqs++;
        aggregate_request(opcode, net_address, prefix_len);
      end
    end
    pending    <= expected_blocks.size();
    fail_count <= misses;
    req_count  <= reqs;
    blk_count  <= blks;
  end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// testbench: stimulus and verdict for ipv4_prefix_aggregator; checking is done by
// ipa_block_checker beside the block. Uses ipa_pkg.
module testbench;
  import ipa_pkg::*;

  // Longest legal quiet stretch is the HOLD_CYCLES output hold-off plus a few
  // geometric idle/stall gaps; this is many times that.
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_CYCLES = 200;
  localparam int PHASE_ITEMS = 107;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic        opcode;
  logic [31:0] net_address;
  logic [4:0]  prefix_len;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] block_address;
  logic [4:0]  block_prefix;
  logic        last_block;

  int fail_count;
  int pending;
  int req_count;
  int blk_count;

  // Knobs shared between the request driver and the output-side staller.
  int idle_pct;
  int stall_pct;
  int hold_len;
  bit hold_req;
  int sent_items;

  ipv4_prefix_aggregator dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .net_address   (net_address),
    .prefix_len    (prefix_len),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .block_address (block_address),
    .block_prefix  (block_prefix),
    .last_block    (last_block)
  );

  ipa_block_checker block_chk (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .net_address   (net_address),
    .prefix_len    (prefix_len),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .block_address (block_address),
    .block_prefix  (block_prefix),
    .last_block    (last_block),
    .fail_count    (fail_count),
    .pending       (pending),
    .req_count     (req_count),
    .blk_count     (blk_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output side: random stall per cycle, or a long hold-off when the
  // stimulus toggles hold_req. The hold length is counted here.
  initial begin : receiver
    int hold_left;
    bit hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Watchdog: any handshake on either channel resets the quiet count.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d blocks pending",
                 quiet, pending);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one request, optionally after idle cycles, and hold it until taken.
  // Valid is decided before stall is looked at; payload is frozen while stalled.
  task automatic send_req(input logic op, input logic [31:0] addr, input logic [4:0] plen);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    net_address <= addr;
    prefix_len  <= plen;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // long-prefix entries are dropped by the block, so they don't count
    if (op == OP_FLUSH || plen <= DEF_UNIT_PREFIX) sent_items++;
  endtask

  // Sender pause: stop offering and wait for every predicted block.
  // The checker's pending count is registered, hence the first wait.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly long prefixes keep runs cheap; the odd wide one makes big blocks.
  function automatic logic [4:0] pick_len();
    if ($urandom_range(9) == 0) return 5'($urandom_range(17));
    return 5'($urandom_range(24, 18));
  endfunction

  // Mostly contiguous runs with random prefixes, sometimes ended by a flush,
  // otherwise by the next run's start; the rest is random entries and flushes.
  task automatic random_phase(input int target);
    logic [31:0] next_addr;
    logic [31:0] addr;
    logic [4:0]  plen;
    int          stop;
    int          entries;
    int          roll;
    stop = sent_items + target;
    while (sent_items < stop) begin
      roll = $urandom_range(99);
      if (roll < 80) begin
        plen      = pick_len();
        next_addr = $urandom & (32'hFFFF_FFFF << (32 - plen));
        entries   = $urandom_range(8, 1);
        for (int i = 0; i < entries; i++) begin
          addr = next_addr;
          // host bits below one /24 must be ignored
          if ($urandom_range(9) == 0) addr[7:0] = 8'($urandom);
          send_req(OP_ENTRY, addr, plen);
          // a long prefix in the middle must not break the run
          if ($urandom_range(14) == 0)
            send_req(OP_ENTRY, $urandom, 5'($urandom_range(31, 25)));
          next_addr = {addr[31:8], 8'h00} + 32'(64'd1 << (32 - plen));
          plen      = pick_len();
        end
        if ($urandom_range(1) == 1) send_req(OP_FLUSH, $urandom, 5'($urandom));
      end else if (roll < 92) begin
        send_req(OP_ENTRY, $urandom, 5'($urandom));
      end else begin
        send_req(OP_FLUSH, $urandom, 5'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_ENTRY;
    net_address = '0;
    prefix_len  = '0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_len    = 0;
    hold_req    = 1'b0;
    sent_items  = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // --- directed ---
    // flush with nothing open, all-ones fields
    send_req(OP_FLUSH, 32'hFFFF_FFFF, 5'h1F);
    // run 10.0.0.0 built from /24, /24, /23; first one has host bits set
    send_req(OP_ENTRY, 32'h0A00_004D, 5'd24);
    send_req(OP_ENTRY, 32'h0A00_0100, 5'd24);
    send_req(OP_ENTRY, 32'h0A00_0200, 5'd23);
    // over-long prefixes: dropped, run stays open
    send_req(OP_ENTRY, 32'h0A00_0400, 5'd25);
    send_req(OP_ENTRY, 32'h0A00_0400, 5'd31);
    // gap at 10.0.4.0 ends the run and opens a new one, flush closes it
    send_req(OP_ENTRY, 32'h0A00_0500, 5'd24);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd0);
    // whole space twice: second would overflow the run, so it splits
    send_req(OP_ENTRY, 32'h0000_0000, 5'd0);
    send_req(OP_ENTRY, 32'h0000_0000, 5'd0);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd0);
    // run crossing 255.255.255.255 into 0.0.0.0
    send_req(OP_ENTRY, 32'hFFFF_FFFF, 5'd24);
    send_req(OP_ENTRY, 32'h0000_0000, 5'd24);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd0);
    // unaligned base: growing ramp splits into one block per entry
    send_req(OP_ENTRY, 32'h0000_0100, 5'd24);
    send_req(OP_ENTRY, 32'h0000_0200, 5'd23);
    send_req(OP_ENTRY, 32'h0000_0400, 5'd22);
    send_req(OP_ENTRY, 32'h0000_0800, 5'd21);
    send_req(OP_ENTRY, 32'h0000_1000, 5'd20);
    send_req(OP_ENTRY, 32'h0000_2000, 5'd19);
    send_req(OP_FLUSH, 32'h0000_0000, 5'd0);
    drain();

    // --- random, no idling; output held off long enough to back up the input ---
    hold_len = HOLD_CYCLES;
    hold_req <= ~hold_req;
    random_phase(PHASE_ITEMS);
    drain();

    // --- sender mostly idle ---
    idle_pct = 73;
    random_phase(PHASE_ITEMS);
    drain();

    // --- receiver mostly stalled ---
    idle_pct  = 0;
    stall_pct = 73;
    random_phase(PHASE_ITEMS);
    drain();

    // --- light idling on both sides ---
    idle_pct  = 8;
    stall_pct = 8;
    random_phase(PHASE_ITEMS);
    drain();

    // settle: anything that shows up now is unexpected
    stall_pct = 0;
    repeat (2 * MAX_BLOCKS + 16) @(posedge clk);

    $display("run: %0d requests, %0d blocks compared; directed corner cases plus",
             req_count, blk_count);
    $display("     random runs under no idling, sender idle, receiver stall, both light");
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
src/ipa_pkg.sv
src/ipa_ctrl.sv
src/ipa_dp.sv
src/ipv4_prefix_aggregator.sv
tb/sv/ipa_block_checker.sv
tb/sv/testbench.sv
